// ===== rtl/ldfd_pkg.sv =====
// Package for the laser distance frame decoder.
// Holds the shared widths, frame constants, calibration constants and the frame struct.
// No dependencies.
package ldfd_pkg;

  // Field widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned RawW    = 14;
  localparam int unsigned DistW   = 20;
  localparam int unsigned SkipW   = 9;
  localparam int unsigned DecimW  = 8;

  // The reset value of the decimation register.
  localparam logic [DecimW-1:0] DecimReset = 8'd10;

  // The head nibble that marks a reading beyond the linear range.
  localparam logic [3:0] HeadOutNibble = 4'hF;

  // The distance is floor(X / 803) with X = 40000*raw + 46580401.
  // It splits into 49*raw + 58007 + floor((653*raw + 780) / 803).
  localparam int unsigned       RemW        = 24;
  localparam logic [RemW-1:0]   RemMul      = 24'd653;
  localparam logic [RemW-1:0]   RemAdd      = 24'd780;
  localparam logic [DistW-1:0]  BaseMul     = 20'd49;
  localparam logic [DistW-1:0]  BaseAdd     = 20'd58007;

  // Reciprocal of 803 for a 24-bit dividend: ceil(2^34 / 803).
  localparam int unsigned       RecipW      = 25;
  localparam int unsigned       RecipShift  = 34;
  localparam logic [RecipW-1:0] RecipMul    = 25'd21394607;
  localparam int unsigned       ProdW       = RemW + RecipW;
  localparam int unsigned       QuotW       = 14;

  // One detected frame.
  typedef struct packed {
    logic [RawW-1:0] raw;
    logic            beyond;
  } ldfd_frame_t;

endpackage

// ===== rtl/laser_distance_frame_decoder.sv =====
// Top level of the laser distance frame decoder.
// Joins the frame detector and the calibration pipeline; depends on ldfd_pkg,
// ldfd_framer and ldfd_calib.
//
//   Channel   Direction  Content
//   s_axis    in         tdata = data_byte, tlast = end_of_read
//   m_axis    out        tdata = distance_milli, raw_count; tuser = beyond_linear
//   cfg       in         decimation_factor, written when cfg_we_i is high
//
// One byte is taken every cycle while s_axis_tready is high. The frame register
// loads at the edge that accepts a frame's tail beat, then the split, reciprocal
// product and output registers follow in that order. Reset clears the held byte,
// the skip count and all valid flags, and sets the decimation factor to 10. A
// stall on m_axis fills the pipeline first; s_axis_tready drops only once every
// stage is full.
module laser_distance_frame_decoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ldfd_pkg::DecimW-1:0]        cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // [7:0] data_byte
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [39:0]                        m_axis_tdata,   // [19:0] distance_milli,
                                                             // [33:20] raw_count, rest 0
  output logic                               m_axis_tuser    // beyond_linear
);
  import ldfd_pkg::*;

  logic              frame_valid;
  logic              frame_ready;
  ldfd_frame_t       frame;
  logic [DistW-1:0]  dist_milli;
  logic [RawW-1:0]   raw;

  // Byte tracking and frame detection.
  ldfd_framer u_framer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_byte_i     (s_axis_tdata),
    .in_last_i     (s_axis_tlast),
    .frame_valid_o (frame_valid),
    .frame_ready_i (frame_ready),
    .frame_o       (frame)
  );

  // Distance calibration and output beat.
  ldfd_calib u_calib (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid),
    .frame_ready_o (frame_ready),
    .frame_i       (frame),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .dist_o        (dist_milli),
    .raw_o         (raw),
    .beyond_o      (m_axis_tuser)
  );

  // Pack the result beat, padded to whole bytes.
  assign m_axis_tdata = {6'b0, raw, dist_milli};

endmodule

// ===== rtl/ldfd_framer.sv =====
// Frame detection for the laser distance frame decoder.
// Tracks the held byte and skip count, and registers each frame found.
// Depends on ldfd_pkg.
module ldfd_framer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ldfd_pkg::DecimW-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ldfd_pkg::ByteW-1:0]   in_byte_i,
  input  logic                         in_last_i,
  output logic                         frame_valid_o,
  input  logic                         frame_ready_i,
  output ldfd_pkg::ldfd_frame_t        frame_o
);
  import ldfd_pkg::*;

  logic [DecimW-1:0] decim_q;
  logic [ByteW-1:0]  held_q, held_d;
  logic              held_v_q, held_v_d;
  logic [SkipW-1:0]  skip_q, skip_d;
  logic [SkipW-1:0]  skip_load;
  logic              frame_v_q, frame_v_d;
  ldfd_frame_t       frame_q, frame_d;
  logic              accept;
  logic              is_frame;

  // The frame register takes a new entry when empty or when it drains this cycle.
  assign in_ready_o = !frame_v_q || frame_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // A frame is a held head byte followed by a tail byte, outside the skip window.
  assign is_frame  = (skip_q == '0) && held_v_q && held_q[ByteW-1] && !in_byte_i[ByteW-1];
  assign skip_load = (decim_q == '0) ? '0 : ({1'b0, decim_q} << 1) - SkipW'(1);

  // Next value of the byte tracking state.
  always_comb begin
    held_d   = held_q;
    held_v_d = held_v_q;
    skip_d   = skip_q;
    if (accept) begin
      if (skip_q != '0) begin
        skip_d = skip_q - SkipW'(1);
      end else if (is_frame) begin
        skip_d = skip_load;
      end
      held_d   = in_byte_i;
      held_v_d = 1'b1;
      if (in_last_i) begin
        held_d   = '0;
        held_v_d = 1'b0;
        skip_d   = '0;
      end
    end
  end

  // Next value of the frame register.
  always_comb begin
    frame_v_d = frame_v_q;
    frame_d   = frame_q;
    if (in_ready_o) begin
      frame_v_d = accept && is_frame;
      frame_d.raw    = {held_q[ByteW-2:0], in_byte_i[ByteW-2:0]};
      frame_d.beyond = (held_q[ByteW-1:ByteW-4] == HeadOutNibble);
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_q   <= DecimReset;
      held_q    <= '0;
      held_v_q  <= 1'b0;
      skip_q    <= '0;
      frame_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        decim_q <= cfg_wdata_i;
      end
      held_q    <= held_d;
      held_v_q  <= held_v_d;
      skip_q    <= skip_d;
      frame_v_q <= frame_v_d;
    end
  end

  // Frame payload needs no reset.
  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  assign frame_valid_o = frame_v_q;
  assign frame_o       = frame_q;

endmodule

// ===== rtl/ldfd_calib.sv =====
// Distance calibration pipeline for the laser distance frame decoder.
// Turns a raw count into thousandths through a reciprocal divide, then holds the result.
// Depends on ldfd_pkg.
module ldfd_calib (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        frame_valid_i,
  output logic                        frame_ready_o,
  input  ldfd_pkg::ldfd_frame_t       frame_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ldfd_pkg::DistW-1:0]  dist_o,
  output logic [ldfd_pkg::RawW-1:0]   raw_o,
  output logic                        beyond_o
);
  import ldfd_pkg::*;

  logic              v2_q, v3_q, vo_q;
  logic              rdy2, rdy3, rdyo;
  logic [RemW-1:0]   rem2_q;
  logic [DistW-1:0]  base2_q, base3_q;
  ldfd_frame_t       frm2_q, frm3_q;
  logic [ProdW-1:0]  prod;
  logic [QuotW-1:0]  quot3_q;
  logic [DistW-1:0]  dist_q;
  logic [RawW-1:0]   raw_q;
  logic              beyond_q;

  // Each stage moves on when it is empty or the stage after it moves.
  assign rdyo          = !vo_q || out_ready_i;
  assign rdy3          = !v3_q || rdyo;
  assign rdy2          = !v2_q || rdy3;
  assign frame_ready_o = rdy2;

  assign prod = ProdW'(rem2_q) * ProdW'(RecipMul);

  // Valid flags of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy2) v2_q <= frame_valid_i;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  // Stage two splits the divide into a whole part and a small remainder term.
  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      rem2_q  <= RemW'(frame_i.raw) * RemMul + RemAdd;
      base2_q <= DistW'(frame_i.raw) * BaseMul + BaseAdd;
      frm2_q  <= frame_i;
    end
  end

  // Stage three divides the remainder term by 803 through its reciprocal.
  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      quot3_q <= prod[RecipShift +: QuotW];
      base3_q <= base2_q;
      frm3_q  <= frm2_q;
    end
  end

  // Output register adds the two parts.
  always_ff @(posedge clk_i) begin
    if (rdyo) begin
      dist_q   <= base3_q + DistW'(quot3_q);
      raw_q    <= frm3_q.raw;
      beyond_q <= frm3_q.beyond;
    end
  end

  assign out_valid_o = vo_q;
  assign dist_o      = dist_q;
  assign raw_o       = raw_q;
  assign beyond_o    = beyond_q;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the laser distance frame decoder: directed and random byte streams
// checked against an in-bench decoder. Depends on ldfd_pkg and laser_distance_frame_decoder.
module tb_top;

  import ldfd_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainCycles = 20;

  // One expected decoder reading.
  typedef struct {
    logic [DistW-1:0] distance;
    logic [RawW-1:0]  raw;
    logic             beyond;
  } reading_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [DecimW-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [39:0]       m_axis_tdata;
  logic              m_axis_tuser;

  // Decoder state mirrored in the bench.
  logic [7:0]        held_q = '0;
  logic              held_ok = 1'b0;
  logic [SkipW-1:0]  skip_left = '0;
  logic [DecimW-1:0] decim = DecimReset;

  reading_t    pending_readings[$];
  int unsigned error_count = 0;
  int unsigned readings_checked = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  int          sink_hold_req = 0;
  int          sink_hold_left = 0;

  laser_distance_frame_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock generation.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and run timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("Timeout after %0d cycles", cycle_count);
    $display("TEST FAILED");
    $finish;
  end

  // Decode one accepted byte and queue the reading it produces, if any.
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    reading_t        rd;
    logic [RawW-1:0] raw;
    longint unsigned num;
    if (skip_left != 0) begin
      skip_left = skip_left - 1'b1;
    end else if (held_ok && held_q >= 8'h80 && b < 8'h80) begin
      raw = {held_q[6:0], b[6:0]};
      num = longint'(raw) * 64'd200000 + 64'd232900000;
      rd.distance = DistW'((2 * num + 64'd4015) / 64'd8030);
      rd.raw = raw;
      rd.beyond = (held_q >= 8'hF0);
      pending_readings.push_back(rd);
      skip_left = (decim == 0) ? '0 : SkipW'({decim, 1'b0} - 9'd1);
    end
    held_q = b;
    held_ok = 1'b1;
    // A chunk end drops the held byte and the skip count.
    if (last) begin
      held_q = '0;
      held_ok = 1'b0;
      skip_left = '0;
    end
  endfunction

  // Offer one byte beat, with an optional idle gap, and wait for its handshake.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (src_idle_en && $urandom_range(0, 99) < 25) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_byte(b, last);
    bytes_sent++;
  endtask

  // Stop offering beats and wait until every expected reading has arrived.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write the decimation register once the decoder is idle.
  task automatic write_decimation(input logic [DecimW-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    decim = value;
  endtask

  // Receiver: random stalls, plus long hold-offs on request.
  always @(posedge clk_i) begin
    if (sink_hold_req > 0) begin
      sink_hold_left = sink_hold_req;
      sink_hold_req = 0;
    end
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !sink_idle_en || ($urandom_range(0, 99) >= 25);
    end
  end

  // Check each output beat against the oldest expected reading.
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t ERROR unexpected reading: expected none, actual tdata %h tuser %b",
                 $time, m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        if (m_axis_tdata[19:0] !== want.distance) begin
          $display("%0t ERROR distance_milli: expected %0d, actual %0d",
                   $time, want.distance, m_axis_tdata[19:0]);
          error_count++;
        end
        if (m_axis_tdata[33:20] !== want.raw) begin
          $display("%0t ERROR raw_count: expected %0d, actual %0d",
                   $time, want.raw, m_axis_tdata[33:20]);
          error_count++;
        end
        if (m_axis_tuser !== want.beyond) begin
          $display("%0t ERROR beyond_linear: expected %b, actual %b",
                   $time, want.beyond, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata[39:34] !== 6'd0) begin
          $display("%0t ERROR tdata padding: expected 0, actual %h",
                   $time, m_axis_tdata[39:34]);
          error_count++;
        end
      end
    end
  end

  // Reset value of the factor: a skip of 19 bytes, the last one reused as a head.
  task automatic test_default_decimation();
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    repeat (18) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h7F, 1'b0);
    drain();
  endtask

  // Field extremes and chunk boundaries with no skip.
  task automatic test_frame_extremes();
    write_decimation(8'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h00, 1'b0);
    // A second head byte replaces the first one.
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h05, 1'b0);
    // The tail is checked at once but cannot start a frame.
    send_byte(8'h10, 1'b0);
    // A head that ends its chunk cannot pair with the next byte.
    send_byte(8'h85, 1'b1);
    send_byte(8'h20, 1'b0);
    // A tail that ends its chunk still completes the frame.
    send_byte(8'h81, 1'b0);
    send_byte(8'h01, 1'b1);
    drain();
  endtask

  // A skipped byte is held as the next head; a chunk end clears the skip.
  task automatic test_skip_and_chunk_end();
    write_decimation(8'd1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'hC4, 1'b0);
    send_byte(8'h3B, 1'b0);
    send_byte(8'hA0, 1'b1);
    send_byte(8'hA1, 1'b0);
    send_byte(8'h02, 1'b0);
    drain();
  endtask

  // Largest factor: 509 skipped bytes between frames.
  task automatic test_max_decimation();
    write_decimation(8'd255);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    repeat (508) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    drain();
  endtask

  // Long receiver hold-off while frames keep coming, so the input stalls.
  task automatic test_backpressure();
    write_decimation(8'd0);
    sink_idle_en = 1'b0;
    sink_hold_req = 300;
    repeat (60) begin
      send_byte(8'($urandom_range(128, 255)), 1'b0);
      send_byte(8'($urandom_range(0, 127)), 1'b0);
    end
    drain();
    sink_idle_en = 1'b1;
  endtask

  // Mostly well-formed frames with random content, plus noise and chunk ends.
  task automatic send_random_run(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned fill;
    int          pick;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_byte(8'($urandom_range(128, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 127)), $urandom_range(0, 99) < 5);
        fill = $urandom_range(0, 2 * decim);
        repeat (fill) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 3);
        sent += 2 + fill;
      end else if (pick < 85) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        sent++;
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        sent++;
      end
    end
  endtask

  // Random phases over several factors; one phase runs with no idling.
  task automatic test_random_stream();
    logic [DecimW-1:0] factors[6];
    factors = '{8'd1, 8'd2, 8'd0, 8'd3, 8'($urandom_range(1, 6)), 8'($urandom_range(4, 12))};
    for (int p = 0; p < 6; p++) begin
      write_decimation(factors[p]);
      src_idle_en = (p != 2);
      sink_idle_en = (p != 2);
      send_random_run(140);
    end
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    drain();
  endtask

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_decimation();
    test_frame_extremes();
    test_skip_and_chunk_end();
    test_max_decimation();
    test_backpressure();
    test_random_stream();
    drain();
    $display("Sent %0d bytes over factors 0 to 255, checked %0d readings.",
             bytes_sent, readings_checked);
    $display("Covered chunk ends, skip reuse, long output stalls and %0d mismatches.",
             error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== laser_distance_frame_decoder.f =====
rtl/ldfd_pkg.sv
rtl/ldfd_framer.sv
rtl/ldfd_calib.sv
rtl/laser_distance_frame_decoder.sv
tb/sv/tb_top.sv
